// ===== design/svl_pkg.sv =====
package svl_pkg;

	// item kinds
	typedef enum logic [1:0] {
		OP_FEEDBACK = 2'd0,
		OP_READ     = 2'd1,
		OP_WRITE    = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_STOPPED   = 2'd1,
		ST_TOO_FAR   = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BLEND_HALF  = 2'd0,
		BLEND_80_20 = 2'd1,
		BLEND_90_10 = 2'd2,
		BLEND_KEEP  = 2'd3
	} blend_t;

	// configuration register indexes
	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_BLEND     = 1'b1
	} reg_idx_t;

	localparam int VEL_W          = 16;
	localparam int KIND_W         = 4;
	localparam int SPEED_W        = 4;
	localparam int SENSOR_W       = 7;
	localparam int CFG_DATA_W     = 16;
	localparam int SLOT_W         = 9;
	localparam int NUM_W          = 19;
	localparam int PROD_W         = 39;
	localparam int MAPPED_SENSORS = 80;

	localparam logic [VEL_W-1:0] THRESHOLD_RST = 16'd1000;

	// x / 5 == (x * ceil(2^22 / 5)) >> 22, exact for x below 2^22
	localparam logic [19:0] DIV5_MAGIC = 20'd838861;
	localparam int          DIV5_SHIFT = 22;

	// track kind per sensor, numbered in order of first appearance
	localparam logic [KIND_W-1:0] SENSOR_KIND [MAPPED_SENSORS] = '{
		4'd0, 4'd0, 4'd1, 4'd2, 4'd0, 4'd0, 4'd0, 4'd3,
		4'd0, 4'd3, 4'd3, 4'd4, 4'd5, 4'd0, 4'd4, 4'd5,
		4'd2, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd6, 4'd1, 4'd2, 4'd1,
		4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd7, 4'd3, 4'd0,
		4'd1, 4'd1, 4'd2, 4'd1, 4'd8, 4'd5, 4'd0, 4'd7,
		4'd6, 4'd1, 4'd2, 4'd2, 4'd1, 4'd1, 4'd7, 4'd7,
		4'd7, 4'd7, 4'd0, 4'd7, 4'd2, 4'd1, 4'd1, 4'd1,
		4'd6, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd7, 4'd8,
		4'd1, 4'd1, 4'd7, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1
	};

	function automatic logic [KIND_W-1:0] sensor_kind(input logic [SENSOR_W-1:0] s);
		logic [KIND_W-1:0] k;
		k = '0;
		if (s < SENSOR_W'(MAPPED_SENSORS)) begin
			k = SENSOR_KIND[s];
		end
		return k;
	endfunction

	// controller to datapath
	typedef struct packed {
		logic clear;    // zero one table entry
		logic capture;  // take the input item
		logic decode;   // check indices, read entry, multiply
		logic finish;   // write back and load the result
	} svl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
	} svl_sts_t;

endpackage

// ===== design/svl_ctrl.sv =====
module svl_ctrl
	import svl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	output logic     result_valid,
	input  logic     result_stall,
	output svl_cmd_t cmd,
	input  svl_sts_t sts
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || !result_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.clear   = (state_q == S_CLEAR);
		cmd.capture = (state_q == S_IDLE) && item_valid;
		cmd.decode  = (state_q == S_DECODE);
		cmd.finish  = (state_q == S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

endmodule

// ===== design/svl_datapath.sv =====
module svl_datapath
	import svl_pkg::*;
#(
	parameter int SPEED_LEVELS = 14,
	parameter int TRACK_KINDS  = 9,
	parameter int SENSOR_COUNT = 80
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  svl_cmd_t              cmd,
	output svl_sts_t              sts,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]            op,
	input  logic [SPEED_W-1:0]    speed_level,
	input  logic [SENSOR_W-1:0]   sensor_index,
	input  logic [KIND_W-1:0]     track_kind,
	input  logic [VEL_W-1:0]      measured_velocity,
	input  logic [VEL_W-1:0]      expected_velocity,
	output logic [VEL_W-1:0]      velocity,
	output logic [KIND_W-1:0]     resolved_kind,
	output logic [1:0]            status
);

	localparam int DEPTH = SPEED_LEVELS * TRACK_KINDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// configuration
	logic [VEL_W-1:0] threshold_q;
	blend_t           blend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			blend_q     <= BLEND_HALF;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_BLEND:     blend_q     <= blend_t'(cfg_data[1:0]);
				default:       ;
			endcase
		end
	end

	// clearing sweep after reset
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear && !sts.clear_last) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	assign sts.clear_last = (clr_addr_q == AW'(DEPTH - 1));

	// capture stage: item fields plus the adds that need only them
	op_t                  op_q;
	logic [SPEED_W-1:0]   speed_q;
	logic [SENSOR_W-1:0]  sensor_q;
	logic [KIND_W-1:0]    kind_q;
	logic [VEL_W-1:0]     meas_q;
	logic [VEL_W-1:0]     avg_q;
	logic [NUM_W-1:0]     num_q;
	logic                 too_far_q;

	logic [VEL_W:0]       avg_sum;
	logic [VEL_W-1:0]     diff;
	logic [NUM_W:0]       sum9;
	logic [NUM_W-1:0]     num;

	always_comb begin
		avg_sum = {1'b0, measured_velocity} + {1'b0, expected_velocity};
		diff    = (measured_velocity >= expected_velocity) ?
		          (measured_velocity - expected_velocity) :
		          (expected_velocity - measured_velocity);
		sum9    = ((NUM_W+1)'(expected_velocity) << 3) + (NUM_W+1)'(expected_velocity)
		        + (NUM_W+1)'(measured_velocity);
		// 90/10 divides (9e+m)/2 by five; 80/20 divides 4e+m by five
		if (blend_q == BLEND_90_10) begin
			num = sum9[NUM_W:1];
		end else begin
			num = (NUM_W'(expected_velocity) << 2) + NUM_W'(measured_velocity);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= op_t'(op);
			speed_q   <= speed_level;
			sensor_q  <= sensor_index;
			kind_q    <= track_kind;
			meas_q    <= measured_velocity;
			avg_q     <= avg_sum[VEL_W:1];
			num_q     <= num;
			too_far_q <= (diff > threshold_q);
		end
	end

	// decode stage
	logic [KIND_W-1:0] col;
	logic              sensor_ok;
	logic              row_ok;
	logic              col_ok;
	status_t           st;
	logic [SLOT_W-1:0] slot_full;
	logic [AW-1:0]     slot;

	always_comb begin
		sensor_ok = (8'(sensor_q) < 8'(MAPPED_SENSORS)) && (8'(sensor_q) < 8'(SENSOR_COUNT));
		col       = (op_q == OP_FEEDBACK) ? sensor_kind(sensor_q) : kind_q;
		row_ok    = (speed_q != '0) && (6'(speed_q) <= 6'(SPEED_LEVELS));
		col_ok    = (5'(col) < 5'(TRACK_KINDS));
		unique case (op_q)
			OP_FEEDBACK: begin
				priority if (speed_q == '0)           st = ST_STOPPED;
				else if (too_far_q)                   st = ST_TOO_FAR;
				else if (sensor_ok && row_ok && col_ok) st = ST_DONE;
				else                                  st = ST_BAD_INDEX;
			end
			OP_READ, OP_WRITE: st = (row_ok && col_ok) ? ST_DONE : ST_BAD_INDEX;
			default:           st = ST_BAD_INDEX;
		endcase
		slot_full = SLOT_W'(speed_q - SPEED_W'(1)) * SLOT_W'(TRACK_KINDS) + SLOT_W'(col);
		slot      = (st == ST_DONE) ? slot_full[AW-1:0] : '0;
	end

	status_t             status_q;
	logic [KIND_W-1:0]   col_q;
	logic [AW-1:0]       slot_q;
	logic [PROD_W-1:0]   product_q;
	logic [VEL_W-1:0]    rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			status_q  <= st;
			col_q     <= col;
			slot_q    <= slot;
			product_q <= PROD_W'(num_q) * PROD_W'(DIV5_MAGIC);
		end
	end

	// velocity table
	logic [VEL_W-1:0] table_mem [DEPTH];
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [VEL_W-1:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_wa] <= mem_wd;
		end
		if (cmd.decode) begin
			rd_data_q <= table_mem[slot];
		end
	end

	// finish stage
	logic [VEL_W-1:0] new_val;
	logic             done;

	always_comb begin
		done = (status_q == ST_DONE);
		unique case (op_q)
			OP_FEEDBACK: begin
				unique case (blend_q)
					BLEND_HALF:               new_val = avg_q;
					BLEND_80_20, BLEND_90_10: new_val = product_q[DIV5_SHIFT +: VEL_W];
					default:                  new_val = rd_data_q;
				endcase
			end
			OP_WRITE: new_val = meas_q;
			default:  new_val = rd_data_q;
		endcase
		mem_we = cmd.clear || (cmd.finish && done && (op_q != OP_READ));
		mem_wa = cmd.clear ? clr_addr_q : slot_q;
		mem_wd = cmd.clear ? '0 : new_val;
	end

	logic [VEL_W-1:0]  vel_q;
	logic [KIND_W-1:0] res_kind_q;
	status_t           res_status_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			vel_q        <= done ? new_val : '0;
			res_kind_q   <= done ? col_q : '0;
			res_status_q <= status_q;
		end
	end

	assign velocity      = vel_q;
	assign resolved_kind = res_kind_q;
	assign status        = res_status_q;

endmodule

// ===== design/segment_velocity_learner.sv =====
// Each item is taken, then decoded with table read and multiply, then written back as its
// result loads the output register, a step that waits while the previous result is stalled.
// Only then is a new item taken, a limit set by the single-entry read-modify-write of the table.
// Reset: asynchronous, active low; the threshold returns to 1000 and blending to half/half,
// then a clearing pass zeroes the table, one entry per cycle, with item_stall high;
// config writes are taken throughout.
module segment_velocity_learner
	import svl_pkg::*;
#(
	parameter int SPEED_LEVELS = 14,
	parameter int TRACK_KINDS  = 9,
	parameter int SENSOR_COUNT = 80
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input items
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            op,
	input  logic [SPEED_W-1:0]    speed_level,
	input  logic [SENSOR_W-1:0]   sensor_index,
	input  logic [KIND_W-1:0]     track_kind,
	input  logic [VEL_W-1:0]      measured_velocity,
	input  logic [VEL_W-1:0]      expected_velocity,
	// result items
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [VEL_W-1:0]      velocity,
	output logic [KIND_W-1:0]     resolved_kind,
	output logic [1:0]            status
);

	svl_cmd_t cmd;
	svl_sts_t sts;

	// registers are plain flops, so a write is always taken
	assign cfg_ready = 1'b1;

	// controller: sequences clear sweep, take, decode and finish; owns result_valid
	svl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

	// datapath: config registers, index checks, divide-by-constant blend,
	// velocity table and the output register
	svl_datapath #(
		.SPEED_LEVELS (SPEED_LEVELS),
		.TRACK_KINDS  (TRACK_KINDS),
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.op                (op),
		.speed_level       (speed_level),
		.sensor_index      (sensor_index),
		.track_kind        (track_kind),
		.measured_velocity (measured_velocity),
		.expected_velocity (expected_velocity),
		.velocity          (velocity),
		.resolved_kind     (resolved_kind),
		.status            (status)
	);

endmodule

// ===== test/segment_velocity_learner_tb.sv =====
`timescale 1ns / 1ps

module segment_velocity_learner_tb;
	import svl_pkg::*;

	localparam int SPEED_LEVELS   = 14;
	localparam int TRACK_KINDS    = 9;
	localparam int SENSOR_COUNT   = 80;
	localparam int WATCHDOG_LIMIT = 2000;   // well above the clearing pass of all 126 table entries and the result stalls
	localparam int REPORT_LIMIT   = 10;

	// track kind of each sensor, kinds numbered by first appearance along the layout
	localparam logic [KIND_W-1:0] kind_by_sensor [SENSOR_COUNT] = '{
		4'd0, 4'd0, 4'd1, 4'd2, 4'd0, 4'd0, 4'd0, 4'd3, 4'd0, 4'd3, 4'd3, 4'd4, 4'd5, 4'd0, 4'd4, 4'd5,
		4'd2, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd6, 4'd1, 4'd2, 4'd1,
		4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd7, 4'd3, 4'd0, 4'd1, 4'd1, 4'd2, 4'd1, 4'd8, 4'd5, 4'd0, 4'd7,
		4'd6, 4'd1, 4'd2, 4'd2, 4'd1, 4'd1, 4'd7, 4'd7, 4'd7, 4'd7, 4'd0, 4'd7, 4'd2, 4'd1, 4'd1, 4'd1,
		4'd6, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd7, 4'd8, 4'd1, 4'd1, 4'd7, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1
	};

	typedef struct {
		logic [1:0]          op;
		logic [SPEED_W-1:0]  speed;
		logic [SENSOR_W-1:0] sensor;
		logic [KIND_W-1:0]   kind;
		logic [VEL_W-1:0]    meas;
		logic [VEL_W-1:0]    expv;
	} track_item_t;

	typedef struct {
		logic [VEL_W-1:0]  vel;
		logic [KIND_W-1:0] kind;
		logic [1:0]        status;
	} velocity_result_t;

	// DUT ports
	logic                  clk               = 1'b0;
	logic                  arst_n            = 1'b0;
	logic                  cfg_valid         = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index         = REG_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data          = '0;
	logic                  item_valid        = 1'b0;
	logic                  item_stall;
	logic [1:0]            op                = OP_FEEDBACK;
	logic [SPEED_W-1:0]    speed_level       = '0;
	logic [SENSOR_W-1:0]   sensor_index      = '0;
	logic [KIND_W-1:0]     track_kind        = '0;
	logic [VEL_W-1:0]      measured_velocity = '0;
	logic [VEL_W-1:0]      expected_velocity = '0;
	logic                  result_valid;
	logic                  result_stall      = 1'b0;
	logic [VEL_W-1:0]      velocity;
	logic [KIND_W-1:0]     resolved_kind;
	logic [1:0]            status;

	// mirror of the learned table and the two registers
	logic [VEL_W-1:0] learned [1:SPEED_LEVELS][0:TRACK_KINDS-1];
	logic [VEL_W-1:0] threshold = THRESHOLD_RST;
	blend_t           blend_sel = BLEND_HALF;

	track_item_t      items_to_send [$];
	velocity_result_t awaited_results [$];
	track_item_t      on_bus;
	velocity_result_t oldest;

	int unsigned items_issued    = 0;
	int unsigned results_checked = 0;
	int unsigned failures        = 0;
	int unsigned settings_used   = 0;
	int unsigned status_seen [4] = '{0, 0, 0, 0};
	int unsigned gap_left        = 0;
	int unsigned stall_left      = 0;
	int unsigned idle_cycles     = 0;
	bit          no_idle         = 1'b0;

	segment_velocity_learner DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.op                (op),
		.speed_level       (speed_level),
		.sensor_index      (sensor_index),
		.track_kind        (track_kind),
		.measured_velocity (measured_velocity),
		.expected_velocity (expected_velocity),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.velocity          (velocity),
		.resolved_kind     (resolved_kind),
		.status            (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one item to the mirrored table and returns the result it should give.
	// Order of checks: stopped, error window, then indices.
	function automatic velocity_result_t learn_item(track_item_t it);
		velocity_result_t r;
		int unsigned m, e, err, blended;
		m        = it.meas;
		e        = it.expv;
		err      = (m >= e) ? m - e : e - m;
		r.vel    = '0;
		r.kind   = '0;
		r.status = ST_BAD_INDEX;
		case (it.op)
			OP_FEEDBACK: begin
				if (it.speed == 0) begin
					r.status = ST_STOPPED;
				end else if (err > threshold) begin
					r.status = ST_TOO_FAR;
				end else if (it.sensor < SENSOR_COUNT && it.speed <= SPEED_LEVELS) begin
					r.kind = kind_by_sensor[it.sensor];
					case (blend_sel)
						BLEND_HALF:  blended = (m + e) >> 1;
						BLEND_80_20: blended = (4 * e + m) / 5;
						BLEND_90_10: blended = (9 * e + m) / 10;
						default:     blended = learned[it.speed][r.kind];  // entry kept
					endcase
					r.vel                     = blended[VEL_W-1:0];
					learned[it.speed][r.kind] = r.vel;
					r.status                  = ST_DONE;
				end
			end
			OP_READ, OP_WRITE: begin
				if (it.speed != 0 && it.speed <= SPEED_LEVELS && it.kind < TRACK_KINDS) begin
					if (it.op == OP_WRITE) learned[it.speed][it.kind] = it.meas;
					r.vel    = learned[it.speed][it.kind];
					r.kind   = it.kind;
					r.status = ST_DONE;
				end
			end
			default: ;  // unused op: bad index
		endcase
		return r;
	endfunction

	// Mostly well-formed traffic: feedback inside the error window, reads and writes
	// on valid cells; the rest is noise over the full width of every field.
	function automatic track_item_t random_item();
		track_item_t it;
		int unsigned pick, reach;
		int          delta;
		pick      = $urandom_range(0, 99);
		it.op     = OP_FEEDBACK;
		it.speed  = SPEED_W'($urandom_range(1, SPEED_LEVELS));
		it.sensor = SENSOR_W'($urandom_range(0, SENSOR_COUNT - 1));
		it.kind   = KIND_W'($urandom_range(0, TRACK_KINDS - 1));
		it.meas   = 16'($urandom);
		it.expv   = 16'($urandom);
		if (pick < 55) begin
			// a few land just outside the window
			reach = (pick < 48) ? threshold : threshold + 64;
			if (reach > 65535) reach = 65535;
			delta = $urandom_range(0, reach);
			if ($urandom_range(0, 1) == 1)
				it.meas = (it.expv + delta > 65535) ? 16'hFFFF : 16'(it.expv + delta);
			else
				it.meas = (it.expv < delta) ? 16'h0000 : 16'(it.expv - delta);
		end else if (pick < 70) begin
			it.op = OP_READ;
		end else if (pick < 85) begin
			it.op = OP_WRITE;
		end else begin
			it.op     = 2'($urandom_range(0, 3));
			it.speed  = SPEED_W'($urandom_range(0, 15));
			it.sensor = SENSOR_W'($urandom_range(0, 127));
			it.kind   = KIND_W'($urandom_range(0, 15));
		end
		return it;
	endfunction

	task automatic queue_item(input track_item_t it);
		items_to_send.push_back(it);
		items_issued++;
	endtask

	// sender holds off until every result so far is back
	task automatic settle();
		while (results_checked != items_issued) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_THRESHOLD) threshold = data;
		else blend_sel = blend_t'(data[1:0]);
	endtask

	// registers only change with the block drained
	task automatic configure(input logic [CFG_DATA_W-1:0] thr, input blend_t mode);
		settle();
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_BLEND, CFG_DATA_W'(mode));
		settings_used++;
	endtask

	task automatic random_run(input int unsigned count);
		repeat (count) queue_item(random_item());
	endtask

	// Driver: next item goes out once the current one is taken, with random idle gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) awaited_results.push_back(learn_item(on_bus));
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (!no_idle && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(1, 4) - 1;
					item_valid <= 1'b0;
				end else if (items_to_send.size() != 0) begin
					on_bus = items_to_send.pop_front();
					op                <= on_bus.op;
					speed_level       <= on_bus.speed;
					sensor_index      <= on_bus.sensor;
					track_kind        <= on_bus.kind;
					measured_velocity <= on_bus.meas;
					expected_velocity <= on_bus.expv;
					item_valid        <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each taken result against the oldest expectation; stalls come in random bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_checked++;
				if (awaited_results.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("%0t: unexpected result velocity %0d kind %0d status %0d",
							$realtime, velocity, resolved_kind, status);
				end else begin
					oldest = awaited_results.pop_front();
					status_seen[oldest.status]++;
					if (velocity !== oldest.vel || resolved_kind !== oldest.kind ||
							status !== oldest.status) begin
						failures++;
						if (failures <= REPORT_LIMIT)
							$display("%0t: mismatch exp vel %0d kind %0d st %0d, got vel %0d kind %0d st %0d",
								$realtime, oldest.vel, oldest.kind, oldest.status,
								velocity, resolved_kind, status);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog: any handshake counts as progress.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $realtime, idle_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		foreach (learned[s, k]) learned[s][k] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset settings (window 1000, half and half); table cleared at reset
		queue_item('{OP_READ,     1,   0, 0, 0,        0});       // cleared entry
		queue_item('{OP_WRITE,    14,  0, 8, 16'hFFFF, 0});       // top corner
		queue_item('{OP_READ,     14,  0, 8, 0,        0});
		queue_item('{OP_FEEDBACK, 0,   5, 0, 100,      100});     // train stopped
		queue_item('{OP_FEEDBACK, 3,   5, 0, 2001,     1000});    // one past the window
		queue_item('{OP_FEEDBACK, 3,   5, 0, 2000,     1000});    // on the window edge
		queue_item('{OP_FEEDBACK, 14,  79, 0, 16'hFFFF, 16'hFFFF}); // last sensor, full scale
		queue_item('{OP_FEEDBACK, 1,   44, 0, 500,      400});    // long straight
		queue_item('{OP_FEEDBACK, 2,   80, 0, 10,       10});     // first unmapped sensor
		queue_item('{OP_FEEDBACK, 2,   127, 0, 10,      10});
		queue_item('{OP_FEEDBACK, 15,  3, 0, 10,       10});      // speed above the table
		queue_item('{OP_READ,     0,   0, 0, 0,        0});       // stopped row on a read
		queue_item('{OP_WRITE,    15,  0, 0, 1234,     0});
		queue_item('{OP_READ,     1,   0, 9, 0,        0});       // column past the table
		queue_item('{OP_WRITE,    1,   0, 15, 4321,    0});
		queue_item('{OP_UNUSED,   1,   0, 0, 0,        0});

		// zero window: only exact agreement is learned
		configure(16'd0, BLEND_HALF);
		queue_item('{OP_FEEDBACK, 7,   12, 0, 777,     777});
		queue_item('{OP_FEEDBACK, 7,   12, 0, 778,     777});

		// widest window with each weighting at the extremes
		configure(16'hFFFF, BLEND_80_20);
		queue_item('{OP_FEEDBACK, 1,   28, 0, 0,        16'hFFFF});
		queue_item('{OP_FEEDBACK, 14,  37, 0, 16'hFFFF, 0});
		random_run(200);

		configure(16'hFFFF, BLEND_90_10);
		queue_item('{OP_FEEDBACK, 1,   28, 0, 0,        16'hFFFF});
		queue_item('{OP_FEEDBACK, 14,  37, 0, 16'hFFFF, 0});
		random_run(200);

		// unused weighting leaves the entry as it is
		configure(16'd300, BLEND_KEEP);
		queue_item('{OP_FEEDBACK, 14,  79, 0, 300,      0});
		random_run(150);

		configure(16'd0, BLEND_HALF);
		random_run(100);

		configure(16'($urandom), blend_t'($urandom_range(0, 2)));
		random_run(200);
		repeat (2) begin
			configure(16'($urandom_range(0, 3000)), blend_t'($urandom_range(0, 3)));
			random_run(200);
		end

		// last stretch at full rate, no gaps on either side
		configure(16'($urandom_range(500, 5000)), blend_t'($urandom_range(0, 2)));
		no_idle = 1'b1;
		random_run(300);

		settle();
		repeat (4) @(posedge clk);
		$display("%0d items under %0d register settings", items_issued, settings_used + 1);
		$display("results: %0d done, %0d stopped, %0d outside window, %0d bad index",
			status_seen[ST_DONE], status_seen[ST_STOPPED], status_seen[ST_TOO_FAR],
			status_seen[ST_BAD_INDEX]);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/svl_pkg.sv
design/svl_ctrl.sv
design/svl_datapath.sv
design/segment_velocity_learner.sv
test/segment_velocity_learner_tb.sv
